FILE: sv/bsc_pkg.sv
// Shared types, register indexes and sequencer states for the compensation unit.
package bsc_pkg;

  localparam int RawWidth   = 20;
  localparam int TempWidth  = 16;
  localparam int PressWidth = 25;
  localparam int CfgIdxWidth = 8;
  localparam int CfgDataWidth = 64;

  localparam logic [CfgIdxWidth-1:0] REG_TEMP_CALIB = 8'd0;
  localparam logic [CfgIdxWidth-1:0] REG_PRESS_LOW  = 8'd1;
  localparam logic [CfgIdxWidth-1:0] REG_PRESS_HIGH = 8'd2;
  localparam logic [CfgIdxWidth-1:0] REG_PRESS_P9   = 8'd3;

  localparam logic [63:0] TFINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRESS_BASE   = 64'd1048576;
  localparam logic [63:0] PRESS_SCALE  = 64'd3125;
  localparam logic [63:0] TEMP_ROUND   = 64'd128;
  localparam logic [63:0] P1_BIAS      = 64'h0000_8000_0000_0000;
  localparam logic [PressWidth-1:0] PRESS_MAX = '1;

  typedef struct packed {
    logic [RawWidth-1:0] raw_temperature;
    logic [RawWidth-1:0] raw_pressure_reading;
  } item_t;

  typedef struct packed {
    logic signed [TempWidth-1:0] temperature_centi;
    logic [PressWidth-1:0]       pressure_q24_8;
    logic                        pressure_invalid;
  } result_t;

  // Calibration words, widened to 64 bits with their sign where signed
  typedef struct packed {
    logic [63:0] t1, t2, t3;
    logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  } calib_t;

  typedef enum logic [4:0] {
    S_IDLE, S_T1, S_T2, S_T3, S_T4,
    S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7,
    S_DIV, S_P8, S_P9, S_P10, S_FIN, S_OUT
  } state_t;

  function automatic logic [63:0] sext16(input logic [15:0] v);
    sext16 = {{48{v[15]}}, v};
  endfunction

endpackage

FILE: sv/bsc_front.sv
// Input side: takes raw reading words into a two-entry queue.
module bsc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        raw_temperature,
  input  logic [19:0]        raw_pressure_reading,
  output logic               q_valid,
  output bsc_pkg::item_t     q_item,
  input  logic               q_pop
);
  import bsc_pkg::*;

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  // Store an accepted word
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{raw_temperature: raw_temperature,
                         raw_pressure_reading: raw_pressure_reading};
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

endmodule

FILE: sv/bsc_mul.sv
// 64x64 multiplier keeping the low 64 bits, one 32x32 partial product a cycle.
module bsc_mul (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);
  logic [63:0] opa;
  logic [63:0] opb;
  logic [1:0]  phase;
  logic        busy;
  logic [31:0] x;
  logic [31:0] y;
  logic [63:0] pp;

  // Pick the partial product for this phase
  always_comb begin
    case (phase)
      2'd0:    begin x = opa[31:0];  y = opb[31:0];  end
      2'd1:    begin x = opa[31:0];  y = opb[63:32]; end
      default: begin x = opa[63:32]; y = opb[31:0];  end
    endcase
    pp = {32'd0, x} * {32'd0, y};
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      opa <= a;
      opb <= b;
    end
    if (busy) begin
      if (phase == 2'd0) prod <= pp;
      else               prod <= prod + {pp[31:0], 32'd0};
    end
  end

  // Step through three phases, flag the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      phase <= 2'd0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy  <= 1'b1;
          phase <= 2'd0;
        end
      end else if (phase == 2'd2) begin
        busy <= 1'b0;
        done <= 1'b1;
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

endmodule

FILE: sv/bsc_div.sv
// Signed 64-bit divider, truncating, one quotient bit a cycle on magnitudes.
module bsc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic        done,
  output logic [63:0] quot
);
  logic [63:0] rem;
  logic [63:0] q;
  logic [63:0] divisor;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [64:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem, q[63]};
  assign fits   = (rem_sh >= {1'b0, divisor});
  assign quot   = neg ? (64'd0 - q) : q;

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      rem     <= 64'd0;
      q       <= num[63] ? (64'd0 - num) : num;
      divisor <= den[63] ? (64'd0 - den) : den;
      neg     <= num[63] ^ den[63];
    end else if (busy) begin
      rem <= fits ? 64'(rem_sh - {1'b0, divisor}) : rem_sh[63:0];
      q   <= {q[62:0], fits};
    end
  end

  // Count 64 steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 6'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          busy <= 1'b1;
          cnt  <= 6'd0;
        end
      end else begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: sv/bsc_back.sv
// Back side: sequences the compensation math over the shared multiplier and divider.
module bsc_back (
  input  logic             clk,
  input  logic             rst,
  input  bsc_pkg::calib_t  calib,
  input  logic             q_valid,
  input  bsc_pkg::item_t   q_item,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output bsc_pkg::result_t result
);
  import bsc_pkg::*;

  state_t      state;
  state_t      state_next;
  item_t       item;
  logic        wait_unit;
  logic [63:0] a1, tmp, tfine, vsq, v2, x, den, num, p, y, q1, sum;
  logic [63:0] v1, ps;
  logic        temp_neg;
  logic [15:0] tout;
  logic        inval;
  logic [24:0] pout;
  logic [63:0] mul_a, mul_b, prod, quot;
  logic        mul_start, mul_done, div_start, div_done;
  logic        use_mul;
  logic        step_done;
  logic        slot_free;
  logic [63:0] tc, pf;
  logic [24:0] pout_hold;
  logic [15:0] temp_hold;

  assign v1 = tfine - TFINE_OFFSET;
  assign ps = 64'($signed(p) >>> 13);
  assign slot_free = !out_valid || out_ready;

  // Operand select per step
  always_comb begin
    use_mul = 1'b1;
    mul_a   = 64'd0;
    mul_b   = 64'd0;
    case (state)
      S_T1:  begin
        mul_a = {44'd0, item.raw_temperature} >> 3;
        mul_a = mul_a - (calib.t1 << 1);
        mul_b = calib.t2;
      end
      S_T2:  begin
        mul_a = ({44'd0, item.raw_temperature} >> 4) - calib.t1;
        mul_b = mul_a;
      end
      S_T3:  begin mul_a = tmp;   mul_b = calib.t3; end
      S_T4:  begin mul_a = tfine; mul_b = 64'd5; end
      S_P1:  begin mul_a = v1;    mul_b = v1; end
      S_P2:  begin mul_a = vsq;   mul_b = calib.p6; end
      S_P3:  begin mul_a = v1;    mul_b = calib.p5; end
      S_P4:  begin mul_a = vsq;   mul_b = calib.p3; end
      S_P5:  begin mul_a = v1;    mul_b = calib.p2; end
      S_P6:  begin mul_a = P1_BIAS + x; mul_b = calib.p1; end
      S_P7:  begin
        mul_a = ((PRESS_BASE - {44'd0, item.raw_pressure_reading}) << 31) - v2;
        mul_b = PRESS_SCALE;
      end
      S_P8:  begin mul_a = calib.p9; mul_b = ps; end
      S_P9:  begin mul_a = y;        mul_b = ps; end
      S_P10: begin mul_a = calib.p8; mul_b = p; end
      default: use_mul = 1'b0;
    endcase
  end

  assign mul_start = use_mul && !wait_unit;
  assign div_start = (state == S_DIV) && !wait_unit;
  assign step_done = (use_mul && mul_done) || ((state == S_DIV) && div_done);
  assign q_pop     = (state == S_IDLE) && q_valid;

  bsc_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .prod(prod)
  );

  bsc_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(num), .den(den),
    .done(div_done), .quot(quot)
  );

  // Rounding and clamps for the final values
  always_comb begin
    tc = 64'($signed(prod + TEMP_ROUND) >>> 8);
    temp_neg = tc[63];
    if (temp_neg)
      tout = ($signed(tc) < -64'sd32768) ? 16'h8000 : tc[15:0];
    else
      tout = ($signed(tc) > 64'sd32767) ? 16'h7FFF : tc[15:0];
    pf = 64'($signed(sum) >>> 8) + (calib.p7 << 4);
    if (pf[63])                      pout = 25'd0;
    else if (pf > {39'd0, PRESS_MAX}) pout = PRESS_MAX;
    else                              pout = pf[24:0];
  end

  // Next step
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (q_valid) state_next = S_T1;
      S_T1:    if (step_done) state_next = S_T2;
      S_T2:    if (step_done) state_next = S_T3;
      S_T3:    if (step_done) state_next = S_T4;
      S_T4:    if (step_done) state_next = S_P1;
      S_P1:    if (step_done) state_next = S_P2;
      S_P2:    if (step_done) state_next = S_P3;
      S_P3:    if (step_done) state_next = S_P4;
      S_P4:    if (step_done) state_next = S_P5;
      S_P5:    if (step_done) state_next = S_P6;
      S_P6:    if (step_done) begin
        state_next = (64'($signed(prod) >>> 33) == 64'd0) ? S_OUT : S_P7;
      end
      S_P7:    if (step_done) state_next = S_DIV;
      S_DIV:   if (step_done) state_next = S_P8;
      S_P8:    if (step_done) state_next = S_P9;
      S_P9:    if (step_done) state_next = S_P10;
      S_P10:   if (step_done) state_next = S_FIN;
      S_FIN:   state_next = S_OUT;
      S_OUT:   if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wait_unit <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (step_done)                 wait_unit <= 1'b0;
      else if (mul_start || div_start) wait_unit <= 1'b1;
      if (state == S_OUT && slot_free) out_valid <= 1'b1;
      else if (out_ready)              out_valid <= 1'b0;
    end
  end

  // Hold the working values of the current word
  always_ff @(posedge clk) begin
    if (q_pop) begin
      item  <= q_item;
      inval <= 1'b0;
    end
    if (step_done) begin
      case (state)
        S_T1:  a1 <= 64'($signed(prod) >>> 11);
        S_T2:  tmp <= 64'($signed(prod) >>> 12);
        S_T3:  tfine <= a1 + 64'($signed(prod) >>> 14);
        S_T4:  temp_hold <= tout;
        S_P1:  vsq <= prod;
        S_P2:  v2 <= prod;
        S_P3:  v2 <= v2 + (prod << 17) + (calib.p4 << 35);
        S_P4:  x <= 64'($signed(prod) >>> 8);
        S_P5:  x <= x + (prod << 12);
        S_P6:  begin
          den   <= 64'($signed(prod) >>> 33);
          inval <= (64'($signed(prod) >>> 33) == 64'd0);
        end
        S_P7:  num <= prod;
        S_DIV: p <= quot;
        S_P8:  y <= prod;
        S_P9:  q1 <= 64'($signed(prod) >>> 25);
        S_P10: sum <= p + q1 + 64'($signed(prod) >>> 19);
        default: ;
      endcase
    end
    if (state == S_FIN) pout_hold <= pout;
    // Load the output word only once the previous one has left
    if (state == S_OUT && slot_free) begin
      result.temperature_centi <= temp_hold;
      result.pressure_q24_8    <= inval ? 25'd0 : pout_hold;
      result.pressure_invalid  <= inval;
    end
  end

endmodule

FILE: sv/barometric_sensor_compensation_unit.sv
// Each word is sequenced through 14 multiplies, one divide and the pop, finish and output
// steps; a zero divisor skips the divide and the last four multiplies.
// The shared multiplier and the bit-serial divider work on one word at a time;
// a two-word input queue takes words while busy.
// Reset: synchronous, clears the queue, sequencer, output valid and the four
// calibration registers to zero.
module barometric_sensor_compensation_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [63:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [19:0]        raw_temperature,
  input  logic [19:0]        raw_pressure_reading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] temperature_centi,
  output logic [24:0]        pressure_q24_8,
  output logic               pressure_invalid
);
  import bsc_pkg::*;

  logic [47:0] temp_calib;
  logic [63:0] press_calib_low;
  logic [63:0] press_calib_high;
  logic [15:0] press_calib_p9;
  calib_t      calib;
  item_t       q_item;
  logic        q_valid;
  logic        q_pop;
  result_t     result;

  assign cfg_ready = 1'b1;

  // Write calibration registers, drop unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= 48'd0;
      press_calib_low  <= 64'd0;
      press_calib_high <= 64'd0;
      press_calib_p9   <= 16'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TEMP_CALIB: temp_calib       <= cfg_data[47:0];
        REG_PRESS_LOW:  press_calib_low  <= cfg_data;
        REG_PRESS_HIGH: press_calib_high <= cfg_data;
        REG_PRESS_P9:   press_calib_p9   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Unpack calibration words
  always_comb begin
    calib.t1 = {48'd0, temp_calib[15:0]};
    calib.t2 = sext16(temp_calib[31:16]);
    calib.t3 = sext16(temp_calib[47:32]);
    calib.p1 = {48'd0, press_calib_low[15:0]};
    calib.p2 = sext16(press_calib_low[31:16]);
    calib.p3 = sext16(press_calib_low[47:32]);
    calib.p4 = sext16(press_calib_low[63:48]);
    calib.p5 = sext16(press_calib_high[15:0]);
    calib.p6 = sext16(press_calib_high[31:16]);
    calib.p7 = sext16(press_calib_high[47:32]);
    calib.p8 = sext16(press_calib_high[63:48]);
    calib.p9 = sext16(press_calib_p9);
  end

  bsc_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .raw_temperature(raw_temperature), .raw_pressure_reading(raw_pressure_reading),
    .q_valid(q_valid), .q_item(q_item), .q_pop(q_pop)
  );

  bsc_back u_back (
    .clk(clk), .rst(rst), .calib(calib), .q_valid(q_valid), .q_item(q_item),
    .q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready), .result(result)
  );

  assign temperature_centi = result.temperature_centi;
  assign pressure_q24_8    = result.pressure_q24_8;
  assign pressure_invalid  = result.pressure_invalid;

endmodule

FILE: tb/tb_barometric_sensor_compensation_unit.sv
// Testbench for the barometric compensation unit: random and directed readings checked by a scoreboard.
`timescale 1ns / 100ps

module tb_barometric_sensor_compensation_unit;
  import bsc_pkg::*;

  // Compensation predictor and queue of expected readings
  class comp_scoreboard;
    logic [63:0] temp_cal, plo_cal, phi_cal, p9_cal;
    result_t pending[$];
    int errors;

    function new();
      temp_cal = '0; plo_cal = '0; phi_cal = '0; p9_cal = '0; errors = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [63:0] data);
      case (idx)
        REG_TEMP_CALIB: temp_cal = {16'd0, data[47:0]};
        REG_PRESS_LOW:  plo_cal = data;
        REG_PRESS_HIGH: phi_cal = data;
        REG_PRESS_P9:   p9_cal = {48'd0, data[15:0]};
        default: ;
      endcase
    endfunction

    function automatic logic signed [63:0] sx(logic [63:0] w, int pos);
      logic [15:0] f;
      f = w[pos +: 16];
      return {{48{f[15]}}, f};
    endfunction

    // Predict one compensated reading
    function void note_reading(logic [19:0] rt, logic [19:0] rp);
      logic signed [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      logic signed [63:0] d1, a1, d2, a2, tfine, tc, v1, v2, p, ps, q1, q2;
      result_t r;
      t1 = {48'd0, temp_cal[15:0]}; t2 = sx(temp_cal, 16); t3 = sx(temp_cal, 32);
      p1 = {48'd0, plo_cal[15:0]}; p2 = sx(plo_cal, 16);
      p3 = sx(plo_cal, 32); p4 = sx(plo_cal, 48);
      p5 = sx(phi_cal, 0); p6 = sx(phi_cal, 16);
      p7 = sx(phi_cal, 32); p8 = sx(phi_cal, 48);
      p9 = sx(p9_cal, 0);
      d1 = $signed({44'd0, rt}) >>> 3;
      d1 = d1 - (t1 <<< 1);
      a1 = (d1 * t2) >>> 11;
      d2 = ($signed({44'd0, rt}) >>> 4) - t1;
      a2 = (((d2 * d2) >>> 12) * t3) >>> 14;
      tfine = a1 + a2;
      tc = (tfine * 64'sd5 + 64'sd128) >>> 8;
      if (tc < -64'sd32768) r.temperature_centi = 16'sh8000;
      else if (tc > 64'sd32767) r.temperature_centi = 16'sh7fff;
      else r.temperature_centi = tc[15:0];
      v1 = tfine - 64'sd128000;
      v2 = v1 * v1 * p6;
      v2 = v2 + ((v1 * p5) <<< 17);
      v2 = v2 + (p4 <<< 35);
      v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
      v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
      r.pressure_q24_8 = '0;
      r.pressure_invalid = 1'b0;
      if (v1 == 0) begin
        r.pressure_invalid = 1'b1;
      end else begin
        p = 64'sd1048576 - $signed({44'd0, rp});
        p = ((p <<< 31) - v2) * 64'sd3125;
        // most negative over minus one wraps to itself
        if (p == 64'sh8000_0000_0000_0000 && v1 == -64'sd1) p = p;
        else p = p / v1;
        ps = p >>> 13;
        q1 = (p9 * ps * ps) >>> 25;
        q2 = (p8 * p) >>> 19;
        p = ((p + q1 + q2) >>> 8) + (p7 <<< 4);
        if (p < 0) r.pressure_q24_8 = '0;
        else if (p > 64'sd33554431) r.pressure_q24_8 = PRESS_MAX;
        else r.pressure_q24_8 = p[24:0];
      end
      pending.push_back(r);
    endfunction

    function void check_reading(result_t got);
      result_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected word t=%0d p=%0d inv=%0b", $time,
                 got.temperature_centi, got.pressure_q24_8, got.pressure_invalid);
        return;
      end
      exp_r = pending.pop_front();
      if (got.temperature_centi !== exp_r.temperature_centi) begin
        errors++;
        $display("%0t: temperature expected %0d actual %0d", $time,
                 exp_r.temperature_centi, got.temperature_centi);
      end
      if (got.pressure_q24_8 !== exp_r.pressure_q24_8) begin
        errors++;
        $display("%0t: pressure expected %0d actual %0d", $time,
                 exp_r.pressure_q24_8, got.pressure_q24_8);
      end
      if (got.pressure_invalid !== exp_r.pressure_invalid) begin
        errors++;
        $display("%0t: invalid flag expected %0b actual %0b", $time,
                 exp_r.pressure_invalid, got.pressure_invalid);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [19:0] raw_temperature = '0;
  logic [19:0] raw_pressure_reading = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] temperature_centi;
  logic [24:0] pressure_q24_8;
  logic pressure_invalid;

  comp_scoreboard sb = new();
  bit quiet_phase = 1'b0;
  int hold_off = 0;

  barometric_sensor_compensation_unit dut (.*);

  always #5 clk = ~clk;

  // Drive ready and check words
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_reading('{temperature_centi, pressure_q24_8, pressure_invalid});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 31);
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one word; valid stays high into the next word unless the sender idles
  task automatic send_reading(logic [19:0] rt, logic [19:0] rp);
    while (!quiet_phase && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; raw_temperature <= rt; raw_pressure_reading <= rp;
    do @(posedge clk); while (!in_ready);
    sb.note_reading(rt, rp);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  // Typical datasheet-like calibration set
  task automatic load_typical();
    write_reg(REG_TEMP_CALIB, {16'd0, 16'hFC18, 16'd26435, 16'd27504});
    write_reg(REG_PRESS_LOW, {16'd2855, 16'd4285, 16'hD5D0, 16'd36477});
    write_reg(REG_PRESS_HIGH, {16'hEC38, 16'd15500, 16'hFFF9, 16'd140});
    write_reg(REG_PRESS_P9, 64'd6000);
  endtask

  task automatic load_random();
    write_reg(REG_TEMP_CALIB, {$urandom, $urandom});
    write_reg(REG_PRESS_LOW, {$urandom, $urandom});
    write_reg(REG_PRESS_HIGH, {$urandom, $urandom});
    write_reg(REG_PRESS_P9, {$urandom, $urandom});
  endtask

  task automatic random_readings(int n);
    for (int i = 0; i < n; i++)
      send_reading(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // zero calibration: divisor is zero
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    drain();
    load_typical();
    send_reading(20'd519888, 20'd415148);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'hFFFFF, 20'd0);
    send_reading(20'd0, 20'hFFFFF);
    send_reading(20'h55555, 20'hAAAAA);
    send_reading(20'hAAAAA, 20'h55555);
    drain();
    // extreme calibration: saturates temperature, clamps pressure both ways
    write_reg(REG_TEMP_CALIB, {16'd0, 16'h7FFF, 16'h7FFF, 16'h0000});
    write_reg(REG_PRESS_LOW, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF});
    write_reg(REG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PRESS_P9, 64'h8000);
    write_reg(8'd9, 64'hDEAD);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd400000, 20'd300000);
    drain();
    write_reg(REG_TEMP_CALIB, {16'd0, 16'h8000, 16'h8000, 16'hFFFF});
    write_reg(REG_PRESS_LOW, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001});
    write_reg(REG_PRESS_HIGH, 64'h7FFF_7FFF_7FFF_7FFF);
    write_reg(REG_PRESS_P9, 64'hFFFF_FFFF_FFFF_7FFF);
    send_reading(20'd0, 20'd0);
    send_reading(20'hFFFFF, 20'hFFFFF);
    send_reading(20'd123456, 20'd654321);
    drain();
    // long receiver hold-off while input keeps coming
    load_typical();
    hold_off = 600;
    random_readings(8);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph[0]) load_random(); else load_typical();
      quiet_phase = (ph == 2);
      random_readings(80);
      drain();
    end
    quiet_phase = 1'b0;
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("barometric_sensor_compensation_unit: match");
    end else begin
      $display("barometric_sensor_compensation_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("barometric_sensor_compensation_unit: mismatch");
    $finish;
  end

endmodule
